FILE: sv/ufw_pkg.sv
`timescale 1ns / 1ps
package ufw_pkg;

   // most result words one input byte can cause
   localparam int RSP_MAX = 3;

   // match stage codes
   localparam logic [2:0] STAGE_IDLE  = 3'd0;
   localparam logic [2:0] STAGE_E3    = 3'd1;
   localparam logic [2:0] STAGE_E3_80 = 3'd2;
   localparam logic [2:0] STAGE_EF    = 3'd3;
   localparam logic [2:0] STAGE_EF_BC = 3'd4;

   // byte codes of the folded sequences
   localparam logic [7:0] BYTE_E3     = 8'hE3;
   localparam logic [7:0] BYTE_EF     = 8'hEF;
   localparam logic [7:0] BYTE_80     = 8'h80;
   localparam logic [7:0] BYTE_BC     = 8'hBC;
   localparam logic [7:0] BYTE_DIG_LO = 8'h90;
   localparam logic [7:0] BYTE_DIG_HI = 8'h99;
   localparam logic [7:0] BYTE_STOP   = 8'h8E;
   localparam logic [7:0] ASCII_SPACE = 8'h20;
   localparam logic [7:0] ASCII_STOP  = 8'h2E;
   localparam logic [3:0] ASCII_DIG_HI_NIB = 4'h3;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       text_end;
   } rsp_word_type;

   typedef rsp_word_type [RSP_MAX-1:0] rsp_list_type;

   typedef struct packed {
      rsp_list_type words;   // words[0] goes out first
      logic [1:0]   count;
   } fold_type;

endpackage

FILE: sv/ufw_fold.sv
`timescale 1ns / 1ps
module ufw_fold (
   input  logic [2:0]        stage,
   input  logic [7:0]        data_byte,
   input  logic              final_byte,
   output ufw_pkg::fold_type fold,
   output logic [2:0]        next_stage
);

   logic [1:0]  held_count;
   logic [7:0]  held0;
   logic [7:0]  held1;
   logic        full_hit;
   logic [7:0]  conv_byte;
   logic        is_digit;
   logic [1:0]  last_idx;

   always_comb begin
      unique case (stage)
         ufw_pkg::STAGE_E3: begin
            held_count = 2'd1; held0 = ufw_pkg::BYTE_E3; held1 = ufw_pkg::BYTE_80;
         end
         ufw_pkg::STAGE_E3_80: begin
            held_count = 2'd2; held0 = ufw_pkg::BYTE_E3; held1 = ufw_pkg::BYTE_80;
         end
         ufw_pkg::STAGE_EF: begin
            held_count = 2'd1; held0 = ufw_pkg::BYTE_EF; held1 = ufw_pkg::BYTE_BC;
         end
         ufw_pkg::STAGE_EF_BC: begin
            held_count = 2'd2; held0 = ufw_pkg::BYTE_EF; held1 = ufw_pkg::BYTE_BC;
         end
         default: begin
            // unused codes behave as idle
            held_count = 2'd0; held0 = ufw_pkg::BYTE_E3; held1 = ufw_pkg::BYTE_80;
         end
      endcase
   end

   assign is_digit = (data_byte >= ufw_pkg::BYTE_DIG_LO) && (data_byte <= ufw_pkg::BYTE_DIG_HI);

   always_comb begin
      full_hit  = 1'b0;
      conv_byte = ufw_pkg::ASCII_SPACE;
      if (stage == ufw_pkg::STAGE_E3_80 && data_byte == ufw_pkg::BYTE_80) begin
         full_hit  = 1'b1;
         conv_byte = ufw_pkg::ASCII_SPACE;
      end else if (stage == ufw_pkg::STAGE_EF_BC && is_digit) begin
         full_hit  = 1'b1;
         conv_byte = {ufw_pkg::ASCII_DIG_HI_NIB, data_byte[3:0]};
      end else if (stage == ufw_pkg::STAGE_EF_BC && data_byte == ufw_pkg::BYTE_STOP) begin
         full_hit  = 1'b1;
         conv_byte = ufw_pkg::ASCII_STOP;
      end
   end

   always_comb begin
      fold       = '0;
      next_stage = ufw_pkg::STAGE_IDLE;
      if (full_hit) begin
         fold.words[0].out_byte = conv_byte;
         fold.count             = 2'd1;
      end else if (!final_byte && stage == ufw_pkg::STAGE_E3
                   && data_byte == ufw_pkg::BYTE_80) begin
         next_stage = ufw_pkg::STAGE_E3_80;
      end else if (!final_byte && stage == ufw_pkg::STAGE_EF
                   && data_byte == ufw_pkg::BYTE_BC) begin
         next_stage = ufw_pkg::STAGE_EF_BC;
      end else begin
         // broken prefix: held bytes go out unchanged, new byte rescanned alone
         fold.words[0].out_byte = held0;
         fold.words[1].out_byte = held1;
         if (!final_byte && data_byte == ufw_pkg::BYTE_E3) begin
            next_stage = ufw_pkg::STAGE_E3;
            fold.count = held_count;
         end else if (!final_byte && data_byte == ufw_pkg::BYTE_EF) begin
            next_stage = ufw_pkg::STAGE_EF;
            fold.count = held_count;
         end else begin
            fold.words[held_count].out_byte = data_byte;
            fold.count = held_count + 2'd1;
         end
      end
      last_idx = fold.count - 2'd1;
      if (fold.count != 2'd0) begin
         fold.words[last_idx].run_last = 1'b1;
         fold.words[last_idx].text_end = final_byte;
      end
   end

endmodule

FILE: sv/ufw_rsp_queue.sv
`timescale 1ns / 1ps
module ufw_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  ufw_pkg::fold_type     fold,
   input  logic                  pop_ready,
   output logic                  free,
   output logic                  word_valid,
   output ufw_pkg::rsp_word_type word
);

   logic [1:0]            rem_ff;
   logic [1:0]            rem_in;
   ufw_pkg::rsp_list_type entries_ff;
   ufw_pkg::rsp_list_type entries_in;
   logic                  pop;

   assign word_valid = (rem_ff != 2'd0);
   assign word       = entries_ff[0];
   assign pop        = word_valid && pop_ready;
   // empty now, or its last word leaves this cycle
   assign free       = (rem_ff == 2'd0) || (rem_ff == 2'd1 && pop_ready);

   always_comb begin
      rem_in     = rem_ff;
      entries_in = entries_ff;
      if (load) begin
         rem_in     = fold.count;
         entries_in = fold.words;
      end else if (pop) begin
         rem_in        = rem_ff - 2'd1;
         entries_in[0] = entries_ff[1];
         entries_in[1] = entries_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 2'd0;
      end else begin
         rem_ff <= rem_in;
      end
      entries_ff <= entries_in;
   end

   a_load_when_free : assert property (@(posedge clock) disable iff (reset)
      load |-> (rem_ff == 2'd0) || (rem_ff == 2'd1 && pop_ready))
      else $error("queue loaded over pending words");

   a_tail_marked : assert property (@(posedge clock) disable iff (reset)
      (rem_ff != 2'd0) |-> entries_ff[rem_ff - 2'd1].run_last)
      else $error("last queued word lacks run_last");

endmodule

FILE: sv/utf8_fullwidth_normalizer_unit.sv
`timescale 1ns / 1ps
// channel   direction  tdata           tuser      tlast
// req       in         data_byte[7:0]  -          final_byte
// rsp       out        out_byte[7:0]   run_last   text_end
//
// a byte is registered on entry and folded from that register into a three-word
// result queue once the queue is free; with rsp_tready high and at most one word
// per byte, one byte moves per cycle. a broken prefix gives up to three words for
// one byte; the queue drains one word a cycle while rsp_tready is high, and a byte
// waiting in the input register holds req_tready low until the last word leaves.
// synchronous reset clears the match stage, the input valid flag and the queue.
module utf8_fullwidth_normalizer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // [0] run_last
   output logic       rsp_tlast
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_final_ff;
   logic [2:0]            stage_ff;
   logic [2:0]            stage_in;
   logic [2:0]            next_stage;
   logic                  load;
   logic                  free;
   logic                  req_accept;
   ufw_pkg::fold_type     fold;
   ufw_pkg::rsp_word_type word;

   ufw_fold u_fold (
      .stage      (stage_ff),
      .data_byte  (in_byte_ff),
      .final_byte (in_final_ff),
      .fold       (fold),
      .next_stage (next_stage)
   );

   ufw_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .fold       (fold),
      .pop_ready  (rsp_tready),
      .free       (free),
      .word_valid (rsp_tvalid),
      .word       (word)
   );

   assign load       = in_valid_ff && free;
   assign req_tready = !in_valid_ff || load;
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tdata = word.out_byte;
   assign rsp_tuser = word.run_last;
   assign rsp_tlast = word.text_end;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
      stage_in = load ? next_stage : stage_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         stage_ff    <= ufw_pkg::STAGE_IDLE;
      end else begin
         in_valid_ff <= in_valid_in;
         stage_ff    <= stage_in;
      end
      if (req_accept) begin
         in_byte_ff  <= req_tdata;
         in_final_ff <= req_tlast;
      end
   end

   a_final_clears_stage : assert property (@(posedge clock) disable iff (reset)
      load && in_final_ff |=> stage_ff == ufw_pkg::STAGE_IDLE)
      else $error("prefix still held after final byte");

   a_silent_means_held : assert property (@(posedge clock) disable iff (reset)
      load && fold.count == 2'd0 |=> stage_ff != ufw_pkg::STAGE_IDLE)
      else $error("byte dropped without a held prefix");

endmodule

FILE: test/tb_utf8_fullwidth_normalizer_unit.sv
`timescale 1ns / 1ps
module tb_utf8_fullwidth_normalizer_unit;

   localparam int CYCLE_LIMIT = 60000;
   localparam int RANDOM_TARGET = 175;

   typedef struct {
      logic [7:0] data;
      logic       fin;
      bit         drain;   // wait for every folded word before offering
   } text_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;
   logic       rsp_tlast;

   text_byte_type         text_bytes[$];
   ufw_pkg::rsp_word_type folded_due[$];
   logic [2:0]            fold_stage = ufw_pkg::STAGE_IDLE;
   int                    mismatch_count = 0;
   int                    words_seen = 0;
   int                    reset_count = 0;
   int                    cycle_count = 0;

   utf8_fullwidth_normalizer_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         reset_count <= reset_count + 1;
         if (reset_count == 6) reset <= 1'b0;
      end
   end

   // folds one accepted byte and queues the words it must produce
   function automatic void fold_text_byte(input logic [7:0] data, input logic fin);
      logic [7:0]            held [0:2];
      ufw_pkg::rsp_word_type words [0:2];
      int                    n;
      int                    pos;
      int                    cnt;
      logic                  hit;
      logic [7:0]            repl;
      n = 0;
      pos = 0;
      cnt = 0;
      case (fold_stage)
         ufw_pkg::STAGE_E3: begin
            held[0] = ufw_pkg::BYTE_E3;
            n = 1;
         end
         ufw_pkg::STAGE_E3_80: begin
            held[0] = ufw_pkg::BYTE_E3;
            held[1] = ufw_pkg::BYTE_80;
            n = 2;
         end
         ufw_pkg::STAGE_EF: begin
            held[0] = ufw_pkg::BYTE_EF;
            n = 1;
         end
         ufw_pkg::STAGE_EF_BC: begin
            held[0] = ufw_pkg::BYTE_EF;
            held[1] = ufw_pkg::BYTE_BC;
            n = 2;
         end
         default: n = 0;
      endcase
      held[n] = data;
      n++;
      fold_stage = ufw_pkg::STAGE_IDLE;
      while (pos < n) begin
         hit = 1'b0;
         repl = 8'h00;
         if (n - pos == 3) begin
            if (held[0] == ufw_pkg::BYTE_E3 && held[1] == ufw_pkg::BYTE_80
                && held[2] == ufw_pkg::BYTE_80) begin
               hit = 1'b1;
               repl = ufw_pkg::ASCII_SPACE;
            end else if (held[0] == ufw_pkg::BYTE_EF && held[1] == ufw_pkg::BYTE_BC) begin
               if (held[2] >= ufw_pkg::BYTE_DIG_LO && held[2] <= ufw_pkg::BYTE_DIG_HI) begin
                  hit = 1'b1;
                  repl = {ufw_pkg::ASCII_DIG_HI_NIB, held[2][3:0]};
               end else if (held[2] == ufw_pkg::BYTE_STOP) begin
                  hit = 1'b1;
                  repl = ufw_pkg::ASCII_STOP;
               end
            end
            if (hit) begin
               words[cnt] = '{out_byte: repl, run_last: 1'b0, text_end: 1'b0};
               cnt++;
               break;
            end
         end else if (!fin) begin
            if (n - pos == 1) begin
               if (held[pos] == ufw_pkg::BYTE_E3) fold_stage = ufw_pkg::STAGE_E3;
               else if (held[pos] == ufw_pkg::BYTE_EF) fold_stage = ufw_pkg::STAGE_EF;
            end else begin
               if (held[pos] == ufw_pkg::BYTE_E3 && held[pos+1] == ufw_pkg::BYTE_80)
                  fold_stage = ufw_pkg::STAGE_E3_80;
               else if (held[pos] == ufw_pkg::BYTE_EF && held[pos+1] == ufw_pkg::BYTE_BC)
                  fold_stage = ufw_pkg::STAGE_EF_BC;
            end
            if (fold_stage != ufw_pkg::STAGE_IDLE) break;
         end
         words[cnt] = '{out_byte: held[pos], run_last: 1'b0, text_end: 1'b0};
         cnt++;
         pos++;
      end
      if (cnt > 0) begin
         words[cnt-1].run_last = 1'b1;
         words[cnt-1].text_end = fin;
      end
      for (int i = 0; i < cnt; i++) folded_due.insert(folded_due.size(), words[i]);
   endfunction

   task automatic add_byte(input logic [7:0] data, input logic fin, input bit drain);
      text_byte_type item;
      item.data = data;
      item.fin = fin;
      item.drain = drain;
      text_bytes.insert(text_bytes.size(), item);
   endtask

   // sender: bursts of random length separated by random gaps
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = $urandom_range(1, 24);
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            fold_text_byte(text_bytes[0].data, text_bytes[0].fin);
            void'(text_bytes.pop_front());
         end
         if (req_tvalid && !req_tready) begin
            // offer stays up until taken
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (text_bytes.size() > 0 &&
                      !(text_bytes[0].drain && folded_due.size() != 0)) begin
            req_tvalid <= 1'b1;
            req_tdata <= text_bytes[0].data;
            req_tlast <= text_bytes[0].fin;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stall mode, redrawn when a phase counter wraps, plus one long hold-off
   int  ready_mode = 0;
   int  mode_phase = 0;
   int  hold_left = 0;
   bit  long_hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (!long_hold_done && words_seen >= 60) begin
            hold_left = 120;
            long_hold_done = 1'b1;
         end
         mode_phase++;
         if (mode_phase >= 40) begin
            mode_phase = 0;
            ready_mode = $urandom_range(0, 3);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (ready_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= ($urandom_range(0, 1) == 1);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : monitor
      ufw_pkg::rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_seen++;
         if (folded_due.size() == 0) begin
            $error("unexpected word: out_byte %02h run_last %0b text_end %0b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            want = folded_due.pop_front();
            if (rsp_tdata !== want.out_byte) begin
               $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser !== want.run_last) begin
               $error("run_last: expected %0b, got %0b", want.run_last, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tlast !== want.text_end) begin
               $error("text_end: expected %0b, got %0b", want.text_end, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("utf8_fullwidth_normalizer_unit test failed");
         $finish;
      end
   end

   initial begin
      logic [7:0] chunk[$];
      logic [7:0] lead;
      int         text_len;
      int         kind;
      int         random_start;

      // extremes, each fold, broken prefixes, rescans and flushes on the last byte
      add_byte(8'h00, 1'b0, 1'b0);
      add_byte(8'hFF, 1'b1, 1'b0);
      add_byte(ufw_pkg::BYTE_E3, 1'b0, 1'b0);
      add_byte(ufw_pkg::BYTE_80, 1'b0, 1'b0);
      add_byte(ufw_pkg::BYTE_80, 1'b0, 1'b0);
      add_byte(ufw_pkg::BYTE_EF, 1'b0, 1'b0);
      add_byte(ufw_pkg::BYTE_BC, 1'b0, 1'b0);
      add_byte(ufw_pkg::BYTE_DIG_LO, 1'b0, 1'b0);
      add_byte(ufw_pkg::BYTE_EF, 1'b0, 1'b0);
      add_byte(ufw_pkg::BYTE_BC, 1'b0, 1'b0);
      add_byte(ufw_pkg::BYTE_STOP, 1'b0, 1'b0);
      add_byte(ufw_pkg::BYTE_E3, 1'b0, 1'b0);
      add_byte(ufw_pkg::BYTE_80, 1'b0, 1'b0);
      add_byte(8'h81, 1'b0, 1'b0);
      add_byte(ufw_pkg::BYTE_EF, 1'b0, 1'b0);
      add_byte(8'h41, 1'b0, 1'b0);
      add_byte(ufw_pkg::BYTE_E3, 1'b0, 1'b0);
      add_byte(ufw_pkg::BYTE_E3, 1'b0, 1'b0);
      add_byte(ufw_pkg::BYTE_80, 1'b0, 1'b0);
      add_byte(ufw_pkg::BYTE_80, 1'b0, 1'b0);
      add_byte(ufw_pkg::BYTE_EF, 1'b0, 1'b0);
      add_byte(ufw_pkg::BYTE_BC, 1'b0, 1'b0);
      add_byte(ufw_pkg::BYTE_DIG_HI, 1'b1, 1'b0);
      add_byte(ufw_pkg::BYTE_EF, 1'b0, 1'b0);
      add_byte(ufw_pkg::BYTE_BC, 1'b1, 1'b0);

      // random texts built mostly from whole or cut fullwidth sequences
      random_start = text_bytes.size();
      while (text_bytes.size() < random_start + RANDOM_TARGET) begin
         chunk.delete();
         text_len = $urandom_range(1, 8);
         for (int t = 0; t < text_len; t++) begin
            kind = $urandom_range(0, 9);
            case (kind)
               0, 1: begin
                  chunk.insert(chunk.size(), ufw_pkg::BYTE_E3);
                  chunk.insert(chunk.size(), ufw_pkg::BYTE_80);
                  chunk.insert(chunk.size(), ufw_pkg::BYTE_80);
               end
               2, 3, 4: begin
                  // digits plus the near misses on either side
                  chunk.insert(chunk.size(), ufw_pkg::BYTE_EF);
                  chunk.insert(chunk.size(), ufw_pkg::BYTE_BC);
                  chunk.insert(chunk.size(), 8'($urandom_range(8'h8D, 8'h9B)));
               end
               5: begin
                  chunk.insert(chunk.size(), ufw_pkg::BYTE_EF);
                  chunk.insert(chunk.size(), ufw_pkg::BYTE_BC);
                  chunk.insert(chunk.size(), ufw_pkg::BYTE_STOP);
               end
               6: begin
                  lead = ($urandom_range(0, 1) == 0) ? ufw_pkg::BYTE_E3 : ufw_pkg::BYTE_EF;
                  chunk.insert(chunk.size(), lead);
                  if ($urandom_range(0, 1) == 0)
                     chunk.insert(chunk.size(), (lead == ufw_pkg::BYTE_E3) ?
                                  ufw_pkg::BYTE_80 : ufw_pkg::BYTE_BC);
                  if ($urandom_range(0, 1) == 0) begin
                     case ($urandom_range(0, 4))
                        0: chunk.insert(chunk.size(), ufw_pkg::BYTE_80);
                        1: chunk.insert(chunk.size(), ufw_pkg::BYTE_BC);
                        2: chunk.insert(chunk.size(), ufw_pkg::BYTE_E3);
                        3: chunk.insert(chunk.size(), ufw_pkg::BYTE_EF);
                        default: chunk.insert(chunk.size(), 8'($urandom_range(0, 255)));
                     endcase
                  end
               end
               7: chunk.insert(chunk.size(), 8'($urandom_range(8'h20, 8'h7E)));
               default: chunk.insert(chunk.size(), 8'($urandom_range(0, 255)));
            endcase
         end
         for (int i = 0; i < chunk.size(); i++)
            add_byte(chunk[i], i == chunk.size() - 1,
                     text_bytes.size() == random_start || $urandom_range(0, 59) == 0);
      end

      while (reset) @(posedge clock);
      while (text_bytes.size() != 0 || folded_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("utf8_fullwidth_normalizer_unit test passed");
      end else begin
         $display("utf8_fullwidth_normalizer_unit test failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/ufw_pkg.sv
sv/ufw_fold.sv
sv/ufw_rsp_queue.sv
sv/utf8_fullwidth_normalizer_unit.sv
test/tb_utf8_fullwidth_normalizer_unit.sv
